@@ src/sti_pkg.sv @@
package sti_pkg;

  localparam int TIME_W     = 48;
  localparam int ROW_W      = 9;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK0,
    ST_CHKL,
    ST_BS,
    ST_BSC,
    ST_SHIFT,
    ST_WR
  } sti_state_t;

  typedef struct packed {
    logic              vld;
    logic [TIME_W-1:0] new_time;
  } sti_item_t;

endpackage

@@ src/sti_ram.sv @@
module sti_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/sti_front.sv @@
module sti_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [sti_pkg::TIME_W-1:0] in_tdata,
  input  logic                       pop,
  output sti_pkg::sti_item_t         item
);
  import sti_pkg::*;

  logic [TIME_W-1:0] slot_r [2];
  logic              wp_r, wp_nxt;
  logic              rp_r, rp_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              push, take;

  assign in_tready     = (cnt_r != 2'd2);
  assign push          = in_tvalid && in_tready;
  assign take          = pop && (cnt_r != 2'd0);
  assign item.vld      = (cnt_r != 2'd0);
  assign item.new_time = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = take ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= in_tdata;
    end
  end

endmodule

@@ src/sti_back.sv @@
module sti_back #(
  parameter int DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sti_pkg::sti_item_t             item,
  output logic                           pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [sti_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tuser
);
  import sti_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int EXT = (CW > ROW_W) ? CW : ROW_W;

  sti_state_t        state_r, state_nxt;
  logic [TIME_W-1:0] t_r, t_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     row_r, row_nxt;
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     hi_r, hi_nxt;
  logic [CW-1:0]     mid_r, mid_nxt;
  logic              lo_eq_r, lo_eq_nxt;
  logic [CW-1:0]     rptr_r, rptr_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     paddr_r, paddr_nxt;
  logic              ovld_r, ovld_nxt;
  logic [ROW_W-1:0]  orow_r, orow_nxt;
  logic              ofull_r, ofull_nxt;
  logic [ROW_W-1:0]  ocnt_r, ocnt_nxt;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [TIME_W-1:0] ram_wdata, ram_rdata;

  logic              is_full, one_entry, row0_hit, span_gt1, shift_more;
  logic [CW:0]       mid_sum;
  logic [CW-1:0]     mid_c, count_inc;

  assign is_full    = (count_r == CW'(DEPTH));
  assign one_entry  = (count_r == CW'(1));
  assign row0_hit   = one_entry ? (ram_rdata < t_r) : (ram_rdata <= t_r);
  assign span_gt1   = ((hi_r - lo_r) > CW'(1));
  assign mid_sum    = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_c      = mid_sum[CW:1];
  assign shift_more = (rptr_r > row_r);
  assign count_inc  = count_r + CW'(1);
  assign pop        = (state_r == ST_IDLE) && item.vld && !ovld_r;

  assign out_tvalid = ovld_r;
  assign out_tdata  = {{(OUT_DATA_W - 2 * ROW_W){1'b0}}, ocnt_r, orow_r};
  assign out_tuser  = ofull_r;

  sti_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (pop && !is_full) begin
          state_nxt = (count_r == '0) ? ST_WR : ST_CHK0;
        end
      end
      ST_CHK0: begin
        state_nxt = (row0_hit || one_entry) ? ST_SHIFT : ST_CHKL;
      end
      ST_CHKL: begin
        state_nxt = (ram_rdata >= t_r) ? ST_SHIFT : ST_BS;
      end
      ST_BS: begin
        state_nxt = span_gt1 ? ST_BSC : ST_SHIFT;
      end
      ST_BSC: begin
        state_nxt = ST_BS;
      end
      ST_SHIFT: begin
        if (!shift_more && !pend_r) begin
          state_nxt = ST_WR;
        end
      end
      ST_WR: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_r)
      ST_IDLE: begin
        ram_re = pop && !is_full && (count_r != '0);
      end
      ST_CHK0: begin
        ram_re    = !row0_hit && !one_entry;
        ram_raddr = AW'(count_r - CW'(1));
      end
      ST_BS: begin
        ram_re    = span_gt1;
        ram_raddr = mid_c[AW-1:0];
      end
      ST_SHIFT: begin
        ram_re    = shift_more;
        ram_raddr = AW'(rptr_r - CW'(1));
        ram_we    = pend_r;
        ram_waddr = paddr_r + AW'(1);
      end
      ST_WR: begin
        ram_we    = 1'b1;
        ram_waddr = row_r[AW-1:0];
        ram_wdata = t_r;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_comb begin
    t_nxt     = t_r;
    count_nxt = count_r;
    row_nxt   = row_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    lo_eq_nxt = lo_eq_r;
    rptr_nxt  = rptr_r;
    pend_nxt  = pend_r;
    paddr_nxt = paddr_r;
    ovld_nxt  = ovld_r && !out_tready;
    orow_nxt  = orow_r;
    ofull_nxt = ofull_r;
    ocnt_nxt  = ocnt_r;
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          t_nxt   = item.new_time;
          row_nxt = '0;
          if (is_full) begin
            ovld_nxt  = 1'b1;
            orow_nxt  = '0;
            ofull_nxt = 1'b1;
            ocnt_nxt  = ROW_W'(EXT'(count_r));
          end
        end
      end
      ST_CHK0: begin
        rptr_nxt = count_r;
        if (row0_hit) begin
          row_nxt = '0;
        end else if (one_entry) begin
          row_nxt = count_r;
        end
      end
      ST_CHKL: begin
        rptr_nxt  = count_r;
        row_nxt   = count_r;
        lo_nxt    = '0;
        hi_nxt    = count_r - CW'(1);
        lo_eq_nxt = 1'b0;
      end
      ST_BS: begin
        mid_nxt  = mid_c;
        rptr_nxt = count_r;
        if (!span_gt1) begin
          row_nxt = lo_eq_r ? lo_r : hi_r;
        end
      end
      ST_BSC: begin
        if (ram_rdata < t_r) begin
          hi_nxt = mid_r;
        end else begin
          lo_nxt    = mid_r;
          lo_eq_nxt = (ram_rdata == t_r);
        end
      end
      ST_SHIFT: begin
        pend_nxt = shift_more;
        if (shift_more) begin
          rptr_nxt  = rptr_r - CW'(1);
          paddr_nxt = AW'(rptr_r - CW'(1));
        end
      end
      ST_WR: begin
        count_nxt = count_inc;
        ovld_nxt  = 1'b1;
        orow_nxt  = ROW_W'(EXT'(row_r));
        ofull_nxt = 1'b0;
        ocnt_nxt  = ROW_W'(EXT'(count_inc));
      end
      default: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r     <= t_nxt;
    row_r   <= row_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    lo_eq_r <= lo_eq_nxt;
    rptr_r  <= rptr_nxt;
    paddr_r <= paddr_nxt;
    orow_r  <= orow_nxt;
    ofull_r <= ofull_nxt;
    ocnt_r  <= ocnt_nxt;
  end

endmodule

@@ src/sorted_timestamp_insert_unit.sv @@
// Sorted timestamp table, newest entry first, up to DEPTH entries.
// Input stream: one word per timestamp, in_tdata[47:0] = new_time.
// Output stream: one word per input word, in the same order;
//   out_tdata holds insert_row and the entry count after the insert,
//   out_tuser flags a full table (the timestamp is dropped, row 0).
// A two-word input queue takes words while the insert engine works.
// The engine reads the first and last entries, bisects the table in
// about log2(DEPTH) reads, moves the later entries down one row per
// cycle through the single table RAM, then writes the new entry.
// The result is held in an output register until out_tready; the engine
// starts no new word while a result waits, and the input queue fills and
// then drops in_tready.
// Synchronous reset empties the table and both queues; table contents
// need no clearing since only rows below the count are ever read.
module sorted_timestamp_insert_unit #(
  parameter int DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [47:0] new_time
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [8:0] insert_row, [17:9] entry_count, [23:18] zero
  output logic        out_tuser   // [0] table_full
);
  import sti_pkg::*;

  sti_item_t item;
  logic      pop;

  sti_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .pop       (pop),
    .item      (item)
  );

  sti_back #(.DEPTH(DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ src/sti_checker.sv @@
module sti_checker #(
  parameter int DEPTH = 256
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [47:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  localparam logic [8:0] DEPTH_MOD = 9'(DEPTH);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result word valid right after reset");

  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[8:0] == 9'd0 && out_tdata[17:9] == DEPTH_MOD)
    else $error("full-table word has wrong row or count");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser && (DEPTH <= 256) |->
      out_tdata[8:0] < out_tdata[17:9] && out_tdata[23:18] == 6'd0)
    else $error("insert row not below entry count");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("input word changed while stalled");

endmodule

bind sorted_timestamp_insert_unit sti_checker #(.DEPTH(DEPTH)) u_sti_checker (.*);
